[src/mkle_pkg.sv]
// Package for the keypad line editor: field widths, key codes, event codes,
// the shared key transfer struct and the keypad lookup table.
// No dependencies; the files that use it refer to it by scoped names.
package mkle_pkg;

  // Widths of the stream fields.
  localparam int unsigned COL_W      = 4;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned READ_IDX_W = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned TXT_LEN_W  = 6;
  localparam int unsigned EVENT_W    = 2;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // Editing keys.
  localparam logic [CHAR_W-1:0] KEY_DEL = 7'h2A;  // '*'
  localparam logic [CHAR_W-1:0] KEY_CLR = 7'h23;  // '#'

  // Edit event reported with each result.
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 2'd0,
    EV_APPEND = 2'd1,
    EV_DELETE = 2'd2,
    EV_CLEAR  = 2'd3
  } key_event_e;

  // A newly pressed key found by the scanner.
  typedef struct packed {
    logic              hit;
    logic [CHAR_W-1:0] code;
  } key_t;

  // Keypad legend, indexed by column and row (both from zero).
  function automatic logic [CHAR_W-1:0] key_lookup(input logic [1:0] col,
                                                   input logic [1:0] row);
    logic [CHAR_W-1:0] ch;
    case ({col, row})
      4'b00_00: ch = 7'h31;  // '1'
      4'b00_01: ch = 7'h34;  // '4'
      4'b00_10: ch = 7'h37;  // '7'
      4'b00_11: ch = 7'h2A;  // '*'
      4'b01_00: ch = 7'h32;  // '2'
      4'b01_01: ch = 7'h35;  // '5'
      4'b01_10: ch = 7'h38;  // '8'
      4'b01_11: ch = 7'h30;  // '0'
      4'b10_00: ch = 7'h33;  // '3'
      4'b10_01: ch = 7'h36;  // '6'
      4'b10_10: ch = 7'h39;  // '9'
      4'b10_11: ch = 7'h23;  // '#'
      4'b11_00: ch = 7'h41;  // 'A'
      4'b11_01: ch = 7'h42;  // 'B'
      4'b11_10: ch = 7'h43;  // 'C'
      4'b11_11: ch = 7'h44;  // 'D'
      default:  ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/mkle_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Used for the text line storage. No dependencies.
module mkle_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mkle_scan.sv]
// Keypad row scanner: tracks the scan phase, the selected column and the
// key-held flag, and reports a newly pressed key. Depends on mkle_pkg.
module mkle_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,         // advance one scan tick
  input  logic [mkle_pkg::COL_W-1:0]    col_sense_i,
  output logic [mkle_pkg::ROW_W-1:0]    row_drive_o,  // next row pattern
  output mkle_pkg::key_t                key_o
);

  // Phase codes: idle with all rows low, or the row being scanned.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ROW1 = 3'd1;
  localparam logic [2:0] PH_ROW2 = 3'd2;
  localparam logic [2:0] PH_ROW3 = 3'd3;
  localparam logic [2:0] PH_ROW4 = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [1:0] col_q, col_d;
  logic       held_q, held_d;
  logic [1:0] first_low;
  logic       scanning;
  logic       found;
  logic [1:0] row_idx;

  // Lowest column that reads low; column four when none of the others do.
  always_comb begin
    first_low = 2'd3;
    for (int i = 2; i >= 0; i--) begin
      if (!col_sense_i[i]) begin
        first_low = 2'(i);
      end
    end
  end

  assign scanning = (phase_q inside {PH_ROW1, PH_ROW2, PH_ROW3, PH_ROW4});
  assign row_idx  = 2'(phase_q - PH_ROW1);

  // Next scan state.
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    held_d  = held_q;
    found   = 1'b0;
    if (scanning) begin
      if (!col_sense_i[col_q]) begin
        found   = 1'b1;
        held_d  = 1'b1;
        phase_d = PH_IDLE;
      end else if (phase_q != PH_ROW4) begin
        phase_d = phase_q + 3'd1;
      end else begin
        phase_d = PH_IDLE;
      end
    end else begin
      if (col_sense_i != '1) begin
        col_d   = first_low;
        phase_d = PH_ROW1;
      end else begin
        held_d  = 1'b0;
        phase_d = PH_IDLE;
      end
    end
  end

  // Only the first key since release is reported.
  assign key_o.hit  = found && !held_q;
  assign key_o.code = mkle_pkg::key_lookup(col_q, row_idx);

  // Row pattern that goes with the next phase.
  always_comb begin
    case (phase_d)
      PH_ROW1: row_drive_o = 4'b1110;
      PH_ROW2: row_drive_o = 4'b1101;
      PH_ROW3: row_drive_o = 4'b1011;
      PH_ROW4: row_drive_o = 4'b0111;
      default: row_drive_o = 4'b0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      col_q   <= 2'd0;
      held_q  <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      held_q  <= held_d;
    end
  end

endmodule

[src/mkle_line.sv]
// Text line editor: line length, character storage in a RAM, edit events
// and the character read-back. Depends on mkle_pkg and mkle_ram.
module mkle_line #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,    // item transfer
  input  logic [mkle_pkg::READ_IDX_W-1:0]      rd_index_i, // index of that item
  input  logic                                 en_i,       // item leaves stage
  input  mkle_pkg::key_t                       key_i,
  input  logic [mkle_pkg::READ_IDX_W-1:0]      ridx_i,     // index of staged item
  output mkle_pkg::key_event_e                 event_o,
  output logic [mkle_pkg::CHAR_W-1:0]          code_o,
  output logic [mkle_pkg::TXT_LEN_W-1:0]       text_length_o,
  output logic [mkle_pkg::CHAR_W-1:0]          read_char_o
);

  localparam int unsigned LINE_CAP = LINE_BYTES - 1;
  localparam int unsigned LEN_W    = $clog2(LINE_BYTES);
  localparam int unsigned ADDR_W   = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int unsigned IDX_W    = mkle_pkg::READ_IDX_W;
  localparam int unsigned CMP_W    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  localparam int unsigned TXT_W    = mkle_pkg::TXT_LEN_W;
  localparam int unsigned CH_W     = mkle_pkg::CHAR_W;

  logic [LEN_W-1:0]  len_q, len_d;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CH_W-1:0]   rdata;
  logic              fwd_hit_q;
  logic [CH_W-1:0]   fwd_data_q;
  logic              own_hit;
  logic [CH_W-1:0]   ch;

  // Edit decision for the staged key.
  always_comb begin
    len_d   = len_q;
    we      = 1'b0;
    event_o = mkle_pkg::EV_NONE;
    if (key_i.hit) begin
      if (key_i.code == mkle_pkg::KEY_DEL) begin
        event_o = mkle_pkg::EV_DELETE;
        if (len_q != '0) begin
          len_d = len_q - LEN_W'(1);
        end
      end else if (key_i.code == mkle_pkg::KEY_CLR) begin
        event_o = mkle_pkg::EV_CLEAR;
        len_d   = '0;
      end else if (len_q < LEN_W'(LINE_CAP)) begin
        event_o = mkle_pkg::EV_APPEND;
        we      = 1'b1;
        len_d   = len_q + LEN_W'(1);
      end
    end
  end

  assign code_o = (event_o != mkle_pkg::EV_NONE) ? key_i.code : '0;
  assign waddr  = ADDR_W'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (en_i) begin
      len_q <= len_d;
    end
  end

  mkle_ram #(
    .WIDTH  (CH_W),
    .DEPTH  (LINE_CAP),
    .ADDR_W (ADDR_W)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (we && en_i),
    .waddr_i (waddr),
    .wdata_i (key_i.code),
    .re_i    (rd_en_i),
    .raddr_i (ADDR_W'(rd_index_i)),
    .rdata_o (rdata)
  );

  // A write landing in the same cycle as the read sees old data, so the
  // written character is kept alongside the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= we && en_i && (CMP_W'(len_q) == CMP_W'(rd_index_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= key_i.code;
    end
  end

  // Read-back reflects this item's own append as well.
  assign own_hit = we && (CMP_W'(ridx_i) == CMP_W'(len_q));

  always_comb begin
    if (own_hit) begin
      ch = key_i.code;
    end else if (fwd_hit_q) begin
      ch = fwd_data_q;
    end else begin
      ch = rdata;
    end
  end

  assign read_char_o   = (CMP_W'(ridx_i) < CMP_W'(len_d)) ? ch : '0;
  assign text_length_o = TXT_W'(len_d);

endmodule

[src/matrix_keypad_line_editor_top.sv]
// Top level of the keypad line editor: input stage, result register and the
// stream handshakes around the scanner and the line editor.
// Depends on mkle_pkg, mkle_scan, mkle_line (and through it mkle_ram).

// Each input transfer is one keypad scan tick and yields exactly one result
// transfer. The block takes one tick per clock cycle while results are not
// stalled and has no back-pressure of its own. A tick goes through the input
// stage, which issues the text RAM read, and then the result register. The text
// line is held in a single-write, single-read RAM of LINE_BYTES-1 characters,
// whose one read and one write per cycle set that rate. row_drive in each
// result is the pattern to put on the rows before the next col_sense sample.
module matrix_keypad_line_editor_top #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream. tdata: col_sense[3:0], read_index[9:4], zero fill.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [mkle_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // Result stream. tdata: row_drive[3:0], key_event[5:4], key_code[12:6],
  // text_length[18:13], read_char[25:19], zero fill.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [mkle_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned COL_W = mkle_pkg::COL_W;
  localparam int unsigned IDX_W = mkle_pkg::READ_IDX_W;

  logic                          accept;
  logic                          s1_valid_q;
  logic [COL_W-1:0]              cols_q;
  logic [IDX_W-1:0]              ridx_q;
  logic                          s1_adv;
  logic                          out_valid_q;
  logic [mkle_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [mkle_pkg::ROW_W-1:0]     row_drive;
  mkle_pkg::key_t                 key;
  mkle_pkg::key_event_e           key_event;
  logic [mkle_pkg::CHAR_W-1:0]    key_code;
  logic [mkle_pkg::TXT_LEN_W-1:0] text_length;
  logic [mkle_pkg::CHAR_W-1:0]    read_char;

  // Handshake: the staged item moves on whenever the result register is
  // free or being emptied, and a new item can enter behind it.
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cols_q <= s_axis_tdata_i[COL_W-1:0];
      ridx_q <= s_axis_tdata_i[COL_W +: IDX_W];
    end
  end

  mkle_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (s1_adv),
    .col_sense_i (cols_q),
    .row_drive_o (row_drive),
    .key_o       (key)
  );

  mkle_line #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (accept),
    .rd_index_i    (s_axis_tdata_i[COL_W +: IDX_W]),
    .en_i          (s1_adv),
    .key_i         (key),
    .ridx_i        (ridx_q),
    .event_o       (key_event),
    .code_o        (key_code),
    .text_length_o (text_length),
    .read_char_o   (read_char)
  );

  // Pack the result fields.
  assign out_data_d = {6'd0, read_char, text_length, key_code, key_event, row_drive};

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Row drive is either all low or exactly one row low.
  a_row_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[3:0] == 4'b0000 || $countones(~out_data_q[3:0]) == 1))
    else $error("row drive pattern is not idle or a single row");

  // An event carries a key code and no event carries none.
  a_event_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q[5:4] == mkle_pkg::EV_NONE) == (out_data_q[12:6] == '0)))
    else $error("key event and key code disagree");

  // A key event ends the scan, so the rows return to idle.
  a_event_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[5:4] != mkle_pkg::EV_NONE) |-> (out_data_q[3:0] == 4'b0000))
    else $error("scan still running after a key event");

  // A clear always leaves an empty line.
  a_clear_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[5:4] == mkle_pkg::EV_CLEAR) |-> (out_data_q[18:13] == '0))
    else $error("line not empty after clear");

endmodule
